// ----- hw/rtl/lsb_stego_extract_unit_macros.svh -----
// Assertion macros for the LSB steganography extract unit.
// Included by the top level; expects clk and arst_n in scope.
`ifndef LSB_STEGO_EXTRACT_UNIT_MACROS_SVH
`define LSB_STEGO_EXTRACT_UNIT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define LSE_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define LSE_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ----- hw/rtl/lse_pkg.sv -----
// Shared types and constants for the LSB steganography extract unit.
// No dependencies; used by every module of the block.
package lse_pkg;

	typedef struct packed {
		logic [7:0] image_byte;
		logic       first_byte;
	} in_item_t;

	typedef struct packed {
		logic [1:0] status;
		logic [7:0] secret_byte;
		logic       last_byte;
	} out_item_t;

	// One hidden-data bit on its way from the front end to the parser.
	typedef struct packed {
		logic restart;
		logic data_bit;
	} token_t;

	typedef struct packed {
		logic empty;
		logic full;
	} queue_stat_t;

	typedef struct packed {
		logic [15:0] magic_word;
		logic [31:0] expected_ext_len;
		logic [31:0] expected_ext;
	} cfg_t;

	localparam int CFG_INDEX_W = 8;
	localparam int CFG_DATA_W  = 32;

	localparam logic [CFG_INDEX_W-1:0] REG_HEADER_SKIP      = 8'd0;
	localparam logic [CFG_INDEX_W-1:0] REG_MAGIC_WORD       = 8'd1;
	localparam logic [CFG_INDEX_W-1:0] REG_EXPECTED_EXT_LEN = 8'd2;
	localparam logic [CFG_INDEX_W-1:0] REG_EXPECTED_EXT     = 8'd3;

	localparam logic [7:0]  RST_HEADER_SKIP      = 8'd54;
	localparam logic [15:0] RST_MAGIC_WORD       = 16'd9002;
	localparam logic [31:0] RST_EXPECTED_EXT_LEN = 32'd4;
	localparam logic [31:0] RST_EXPECTED_EXT     = 32'd779384948;

	localparam logic [1:0] ST_DATA   = 2'd0;
	localparam logic [1:0] ST_MAGIC  = 2'd1;
	localparam logic [1:0] ST_EXTLEN = 2'd2;
	localparam logic [1:0] ST_EXT    = 2'd3;

endpackage

// ----- hw/rtl/lse_front.sv -----
// Front end: accepts image bytes, counts off the header and turns each
// remaining byte into a data-bit token. Depends on lse_pkg.
module lse_front (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	input  lse_pkg::in_item_t   in_item,
	input  logic [7:0]          header_skip,
	input  lse_pkg::queue_stat_t q_stat,
	output logic                accept,
	output logic                push,
	output lse_pkg::token_t     token
);

	logic       skip_done_q;
	logic [7:0] skip_cnt_q;
	logic       pend_q;

	logic       skip_done_c;
	logic [7:0] skip_cnt_c;
	logic       pend_c;

	assign accept = in_valid && !q_stat.full;

	always_comb begin
		skip_done_c = skip_done_q;
		skip_cnt_c  = skip_cnt_q;
		pend_c      = pend_q;
		push        = 1'b0;
		if (in_item.first_byte) begin
			skip_done_c = 1'b0;
			skip_cnt_c  = '0;
			pend_c      = 1'b1;
		end
		if (!skip_done_c && (skip_cnt_c < header_skip)) begin
			skip_cnt_c = skip_cnt_c + 8'd1;
		end else begin
			skip_done_c = 1'b1;
			push        = accept;
		end
		token.restart  = pend_c;
		token.data_bit = in_item.image_byte[0];
		// The restart mark rides on the first token of the new image only.
		if (push) begin
			pend_c = 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			skip_done_q <= 1'b0;
			skip_cnt_q  <= '0;
			pend_q      <= 1'b0;
		end else if (accept) begin
			skip_done_q <= skip_done_c;
			skip_cnt_q  <= skip_cnt_c;
			pend_q      <= pend_c;
		end
	end

endmodule

// ----- hw/rtl/lse_queue.sv -----
// Short token queue between the front end and the parser.
// Depends on lse_pkg for the token and status types.
module lse_queue #(
	parameter int DEPTH = 4
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 push,
	input  lse_pkg::token_t      push_token,
	input  logic                 pop,
	output lse_pkg::token_t      head,
	output lse_pkg::queue_stat_t stat
);

	localparam int PTR_W = $clog2(DEPTH);
	localparam int CNT_W = $clog2(DEPTH + 1);

	lse_pkg::token_t  slots_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] cnt_q;

	assign head       = slots_q[rd_ptr_q];
	assign stat.empty = (cnt_q == '0);
	assign stat.full  = (cnt_q == CNT_W'(DEPTH));

	always_ff @(posedge clk) begin
		if (push) begin
			slots_q[wr_ptr_q] <= push_token;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + PTR_W'(1);
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + PTR_W'(1);
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + CNT_W'(1);
			end else if (pop && !push) begin
				cnt_q <= cnt_q - CNT_W'(1);
			end
		end
	end

endmodule

// ----- hw/rtl/lse_back.sv -----
// Back end: gathers data bits into fields, checks the magic, extension length and
// extension, emits payload bytes or one error result. Depends on lse_pkg.
module lse_back (
	input  logic                 clk,
	input  logic                 arst_n,
	input  lse_pkg::cfg_t        cfg,
	input  lse_pkg::token_t      head,
	input  lse_pkg::queue_stat_t q_stat,
	input  logic                 out_stall,
	output logic                 pop,
	output logic                 out_valid,
	output lse_pkg::out_item_t   out_item
);

	localparam logic [2:0] PH_MAGIC  = 3'd1;
	localparam logic [2:0] PH_EXTLEN = 3'd2;
	localparam logic [2:0] PH_EXT    = 3'd3;
	localparam logic [2:0] PH_SIZE   = 3'd4;
	localparam logic [2:0] PH_DATA   = 3'd5;
	localparam logic [2:0] PH_IDLE   = 3'd6;

	logic [2:0]  phase_q;
	logic [4:0]  bit_cnt_q;
	logic [31:0] gather_q;
	logic [31:0] remaining_q;
	logic        out_valid_q;
	lse_pkg::out_item_t out_item_q;

	logic [2:0]  phase_c;
	logic [4:0]  bit_cnt_c;
	logic [31:0] gather_c;
	logic [31:0] remaining_c;
	logic        emit;
	lse_pkg::out_item_t res;

	// A token is taken whenever the output register is free or being emptied.
	assign pop       = !q_stat.empty && (!out_valid_q || !out_stall);
	assign out_valid = out_valid_q;
	assign out_item  = out_item_q;

	always_comb begin
		phase_c     = phase_q;
		bit_cnt_c   = bit_cnt_q;
		gather_c    = gather_q;
		remaining_c = remaining_q;
		emit        = 1'b0;
		res.status      = lse_pkg::ST_DATA;
		res.secret_byte = '0;
		res.last_byte   = 1'b0;
		if (head.restart) begin
			phase_c   = PH_MAGIC;
			bit_cnt_c = '0;
			gather_c  = '0;
		end
		if (phase_c != PH_IDLE) begin
			gather_c  = {gather_c[30:0], head.data_bit};
			bit_cnt_c = bit_cnt_c + 5'd1;
			case (phase_c)
				PH_MAGIC: begin
					if (bit_cnt_c == 5'd16) begin
						bit_cnt_c = '0;
						if (gather_c[15:0] != cfg.magic_word) begin
							phase_c       = PH_IDLE;
							emit          = 1'b1;
							res.status    = lse_pkg::ST_MAGIC;
							res.last_byte = 1'b1;
						end else begin
							phase_c  = PH_EXTLEN;
							gather_c = '0;
						end
					end
				end
				PH_EXTLEN: begin
					if (bit_cnt_c == 5'd0) begin
						if (gather_c != cfg.expected_ext_len) begin
							phase_c       = PH_IDLE;
							emit          = 1'b1;
							res.status    = lse_pkg::ST_EXTLEN;
							res.last_byte = 1'b1;
						end else begin
							phase_c  = PH_EXT;
							gather_c = '0;
						end
					end
				end
				PH_EXT: begin
					if (bit_cnt_c == 5'd0) begin
						if (gather_c != cfg.expected_ext) begin
							phase_c       = PH_IDLE;
							emit          = 1'b1;
							res.status    = lse_pkg::ST_EXT;
							res.last_byte = 1'b1;
						end else begin
							phase_c  = PH_SIZE;
							gather_c = '0;
						end
					end
				end
				PH_SIZE: begin
					if (bit_cnt_c == 5'd0) begin
						// A zero or negative length ends the parse silently.
						if ((gather_c == '0) || gather_c[31]) begin
							phase_c = PH_IDLE;
						end else begin
							phase_c     = PH_DATA;
							remaining_c = gather_c;
						end
						gather_c = '0;
					end
				end
				PH_DATA: begin
					if (bit_cnt_c == 5'd8) begin
						bit_cnt_c       = '0;
						remaining_c     = remaining_c - 32'd1;
						emit            = 1'b1;
						res.secret_byte = gather_c[7:0];
						res.last_byte   = (remaining_c == '0);
						gather_c        = '0;
						if (remaining_c == '0) begin
							phase_c = PH_IDLE;
						end
					end
				end
				default: begin
					phase_c = PH_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			gather_q    <= gather_c;
			remaining_q <= remaining_c;
		end
		if (pop && emit) begin
			out_item_q <= res;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q     <= PH_MAGIC;
			bit_cnt_q   <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (pop) begin
				phase_q   <= phase_c;
				bit_cnt_q <= bit_cnt_c;
			end
			if (pop && emit) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

endmodule

// ----- hw/rtl/lsb_stego_extract_unit.sv -----
// LSB steganography extract unit: usage summary below, configuration registers
// and the front/queue/back assembly. Depends on lse_pkg and the macros header.
//
// Input: in_valid/in_stall/in_data carry one image byte per transfer; first_byte
// restarts the parse and counts as the first image byte. Output: out_valid,
// out_stall, out_data carry one payload byte or one error result per transfer.
// Configuration: cfg_valid/cfg_ready/cfg_index/cfg_data write a register;
// cfg_ready is always high, and writes belong to idle periods.
// Throughput is one image byte per cycle while in_stall is low. The front end
// skips the header and queues one token per data byte; the parser drains one
// token per cycle, unless a result is stalled, into an output register, so a
// result passes a queue slot and then the output register. When out_stall holds
// a result, the parser stops, the token queue fills once QUEUE_DEPTH data tokens
// are waiting and in_stall then rises until the result moves on.
// Reset restores the register defaults and leaves the parser at the start of
// an image, so data before any first-byte mark is parsed as a new image.
`include "lsb_stego_extract_unit_macros.svh"

module lsb_stego_extract_unit #(
	parameter int QUEUE_DEPTH = 4
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 in_valid,
	output logic                                 in_stall,
	input  lse_pkg::in_item_t                    in_data,
	output logic                                 out_valid,
	input  logic                                 out_stall,
	output lse_pkg::out_item_t                   out_data,
	input  logic                                 cfg_valid,
	output logic                                 cfg_ready,
	input  logic [lse_pkg::CFG_INDEX_W-1:0]      cfg_index,
	input  logic [lse_pkg::CFG_DATA_W-1:0]       cfg_data
);

	logic [7:0]    header_skip_q;
	lse_pkg::cfg_t cfg_q;

	logic                 accept;
	logic                 push;
	logic                 pop;
	lse_pkg::token_t      push_token;
	lse_pkg::token_t      head;
	lse_pkg::queue_stat_t q_stat;
	logic                 out_is_error;

	assign cfg_ready    = 1'b1;
	assign in_stall     = !accept && q_stat.full;
	assign out_is_error = out_valid && (out_data.status != lse_pkg::ST_DATA);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			header_skip_q          <= lse_pkg::RST_HEADER_SKIP;
			cfg_q.magic_word       <= lse_pkg::RST_MAGIC_WORD;
			cfg_q.expected_ext_len <= lse_pkg::RST_EXPECTED_EXT_LEN;
			cfg_q.expected_ext     <= lse_pkg::RST_EXPECTED_EXT;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				lse_pkg::REG_HEADER_SKIP:      header_skip_q <= cfg_data[7:0];
				lse_pkg::REG_MAGIC_WORD:       cfg_q.magic_word <= cfg_data[15:0];
				lse_pkg::REG_EXPECTED_EXT_LEN: cfg_q.expected_ext_len <= cfg_data;
				lse_pkg::REG_EXPECTED_EXT:     cfg_q.expected_ext <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	lse_front u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_item     (in_data),
		.header_skip (header_skip_q),
		.q_stat      (q_stat),
		.accept      (accept),
		.push        (push),
		.token       (push_token)
	);

	lse_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_token (push_token),
		.pop        (pop),
		.head       (head),
		.stat       (q_stat)
	);

	lse_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_q),
		.head      (head),
		.q_stat    (q_stat),
		.out_stall (out_stall),
		.pop       (pop),
		.out_valid (out_valid),
		.out_item  (out_data)
	);

	`LSE_ASSERT_NOW(a_error_is_last, out_is_error, out_data.last_byte, "error without last marker")
	`LSE_ASSERT_NOW(a_error_byte_zero, out_is_error, out_data.secret_byte == 8'd0, "error with nonzero byte")
	`LSE_ASSERT_NEXT(a_push_fills_queue, push && !pop, !q_stat.empty, "queue empty after a push")

endmodule
